FILE: hw/rtl/dtt_pkg.sv
// ---------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the dirty tile tracker
// Grid size, tile size, derived widths and the word passed along the row cells.
// ---------------------------------------------------------------------------
package dtt_pkg;

	localparam int TILES_WIDE = 32;
	localparam int TILES_HIGH = 16;
	localparam int TILE_SHIFT = 4;

	localparam int COL_W = (TILES_WIDE > 1) ? $clog2(TILES_WIDE) : 1;
	localparam int ROW_W = (TILES_HIGH > 1) ? $clog2(TILES_HIGH) : 1;

	localparam int COORD_W    = 16;
	localparam int TILE_ROW_W = 4;
	localparam int TILE_COL_W = 5;
	localparam int OUT_DATA_W = 16;

	typedef enum logic {
		CMD_MARK = 1'b0,
		CMD_TAKE = 1'b1
	} cmd_t;

	// word travelling down the row chain, one cell per cycle
	typedef struct packed {
		logic                  valid;
		cmd_t                  cmd;
		logic [TILES_WIDE-1:0] mask;
		logic [ROW_W-1:0]      ya;
		logic [ROW_W-1:0]      yb;
		logic                  flag;
		logic [ROW_W-1:0]      row;
		logic [COL_W-1:0]      col;
	} tok_t;

endpackage

FILE: hw/rtl/dtt_decode.sv
// ---------------------------------------------------------------------------
// dtt_decode: rectangle decode
// Converts pixel corners to tile units, clips to the grid and builds the
// column mask for a mark, or an empty search word for a take.
// ---------------------------------------------------------------------------
module dtt_decode
	import dtt_pkg::*;
(
	input  cmd_t                      cmd,
	input  logic signed [COORD_W-1:0] left_x,
	input  logic signed [COORD_W-1:0] top_y,
	input  logic signed [COORD_W-1:0] right_x,
	input  logic signed [COORD_W-1:0] bottom_y,
	output tok_t                      tok
);

	localparam logic signed [COORD_W-1:0] WIDE_S = COORD_W'(TILES_WIDE);
	localparam logic signed [COORD_W-1:0] HIGH_S = COORD_W'(TILES_HIGH);

	logic signed [COORD_W-1:0] xa, ya, xb, yb;
	logic                      off;
	logic [COL_W-1:0]          xa_c, xb_c;
	logic [ROW_W-1:0]          ya_c, yb_c;
	logic [TILES_WIDE-1:0]     mask;

	// floor division by the tile size
	assign xa = left_x >>> TILE_SHIFT;
	assign ya = top_y >>> TILE_SHIFT;
	assign xb = right_x >>> TILE_SHIFT;
	assign yb = bottom_y >>> TILE_SHIFT;

	assign off = (xa >= WIDE_S) || (ya >= HIGH_S) || (xb < 0) || (yb < 0);

	assign xa_c = (xa < 0) ? '0 : xa[COL_W-1:0];
	assign ya_c = (ya < 0) ? '0 : ya[ROW_W-1:0];
	assign xb_c = (xb >= WIDE_S) ? COL_W'(TILES_WIDE - 1) : xb[COL_W-1:0];
	assign yb_c = (yb >= HIGH_S) ? ROW_W'(TILES_HIGH - 1) : yb[ROW_W-1:0];

	always_comb begin
		for (int c = 0; c < TILES_WIDE; c++) begin
			mask[c] = !off && (COL_W'(c) >= xa_c) && (COL_W'(c) <= xb_c);
		end
	end

	always_comb begin
		tok       = '0;
		tok.valid = 1'b1;
		tok.cmd   = cmd;
		if (cmd == CMD_MARK) begin
			tok.mask = mask;
			tok.ya   = ya_c;
			tok.yb   = yb_c;
			tok.flag = !off;
		end
	end

endmodule

FILE: hw/rtl/dtt_cell.sv
// ---------------------------------------------------------------------------
// dtt_cell: one tile row of the dirty map
// Holds the dirty bits of one row, applies a passing mark word or serves a
// passing take word, and hands the word on to the next lower row.
// ---------------------------------------------------------------------------
module dtt_cell
	import dtt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ROW_W-1:0] row_idx,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	logic [TILES_WIDE-1:0] row_q;
	tok_t                  tok_q;
	tok_t                  tok_d;
	logic                  hit_mark;
	logic                  hit_take;
	logic [COL_W-1:0]      top_col;

	assign hit_mark = tok_in.valid && (tok_in.cmd == CMD_MARK)
		&& (row_idx >= tok_in.ya) && (row_idx <= tok_in.yb);
	assign hit_take = tok_in.valid && (tok_in.cmd == CMD_TAKE)
		&& !tok_in.flag && (|row_q);

	// highest dirty column of this row
	always_comb begin
		top_col = '0;
		for (int c = 0; c < TILES_WIDE; c++) begin
			if (row_q[c]) top_col = COL_W'(c);
		end
	end

	always_comb begin
		tok_d = tok_in;
		if (hit_take) begin
			tok_d.flag = 1'b1;
			tok_d.row  = row_idx;
			tok_d.col  = top_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
			if (hit_mark) begin
				row_q <= row_q | tok_in.mask;
			end else if (hit_take) begin
				row_q[top_col] <= 1'b0;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: hw/rtl/dirty_tile_tracker_core.sv
// ---------------------------------------------------------------------------
// dirty_tile_tracker_core: dirty tile map with mark and take commands
// A word passes the entry register, the row cells from the top row down to
// row zero, one row per cycle, and the output register. A new word is taken
// only when the row cell chain is empty and no result waits in the pending slot.
// A new word may enter while the previous result still waits at the output.
// Reset clears the whole map at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module dirty_tile_tracker_core
	import dtt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// left_x[15:0], top_y[31:16], right_x[47:32], bottom_y[63:48]
	input  logic [4*COORD_W-1:0]  s_axis_tdata,
	// cmd[0]
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// on_screen[0], found[1], tile_row[5:2], tile_col[10:6], zero[15:11]
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	tok_t                  dec_tok;
	tok_t                  tk [TILES_HIGH+1];
	logic [TILES_HIGH:0]   tk_valid;
	logic                  chain_busy;
	logic                  in_acc;
	logic [OUT_DATA_W-1:0] exit_data;
	logic [OUT_DATA_W-1:0] out_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] pend_q;
	logic                  pend_valid_q;
	tok_t                  entry_s1;

	dtt_decode u_decode (
		.cmd      (cmd_t'(s_axis_tuser)),
		.left_x   (s_axis_tdata[COORD_W-1:0]),
		.top_y    (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.right_x  (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
		.bottom_y (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
		.tok      (dec_tok)
	);

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s1 <= '0;
		end else begin
			entry_s1 <= in_acc ? dec_tok : '0;
		end
	end

	assign tk[TILES_HIGH] = entry_s1;

	// chain runs from the top row down to row zero
	for (genvar i = 0; i < TILES_HIGH; i++) begin : g_row
		dtt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.row_idx (ROW_W'(i)),
			.tok_in  (tk[i+1]),
			.tok_out (tk[i])
		);
	end

	always_comb begin
		for (int i = 0; i <= TILES_HIGH; i++) begin
			tk_valid[i] = tk[i].valid;
		end
	end

	assign chain_busy    = |tk_valid;
	assign s_axis_tready = !chain_busy && !pend_valid_q;

	always_comb begin
		exit_data = '0;
		if (tk[0].cmd == CMD_MARK) begin
			exit_data[0] = tk[0].flag;
		end else begin
			exit_data[1]   = tk[0].flag;
			exit_data[5:2] = TILE_ROW_W'(tk[0].row);
			exit_data[10:6] = TILE_COL_W'(tk[0].col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_q        <= '0;
			pend_q       <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (tk[0].valid) begin
				if (!out_valid_q || m_axis_tready) begin
					out_q       <= exit_data;
					out_valid_q <= 1'b1;
				end else begin
					pend_q       <= exit_data;
					pend_valid_q <= 1'b1;
				end
			end else if (pend_valid_q && (!out_valid_q || m_axis_tready)) begin
				out_q        <= pend_q;
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench of dirty_tile_tracker_core
// Sends mark and take words over the input stream and keeps a shadow tile map.
// Each result word is checked field by field against the prediction.
// Directed cases cover the grid edges and clipping, random traffic follows.
// ---------------------------------------------------------------------------
module tb;
	import dtt_pkg::*;

	localparam int TILE_COUNT  = TILES_WIDE * TILES_HIGH;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                  on_screen;
		logic                  found;
		logic [TILE_ROW_W-1:0] tile_row;
		logic [TILE_COL_W-1:0] tile_col;
	} tile_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// left_x[15:0], top_y[31:16], right_x[47:32], bottom_y[63:48]
	logic [4*COORD_W-1:0]  s_axis_tdata = '0;
	// cmd[0]
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// on_screen[0], found[1], tile_row[5:2], tile_col[10:6], zero[15:11]
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	bit           shadow_map [TILE_COUNT];
	tile_result_t pending_results [$];
	int           error_count = 0;
	int           cycle_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	dirty_tile_tracker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// floor shift of a signed pixel coordinate into tile units
	function automatic int tile_of(input logic signed [COORD_W-1:0] p);
		logic signed [COORD_W-1:0] t;
		t = p >>> TILE_SHIFT;
		return int'(t);
	endfunction

	function automatic tile_result_t predict_tile_result(input cmd_t c,
			input logic signed [COORD_W-1:0] lx, ty, rx, by);
		tile_result_t r;
		int xa, ya, xb, yb, x, y;
		r = '0;
		if (c == CMD_MARK) begin
			xa = tile_of(lx);
			ya = tile_of(ty);
			xb = tile_of(rx);
			yb = tile_of(by);
			if (xa >= TILES_WIDE || ya >= TILES_HIGH || xb < 0 || yb < 0)
				return r;
			if (xa < 0) xa = 0;
			if (ya < 0) ya = 0;
			if (xb >= TILES_WIDE) xb = TILES_WIDE - 1;
			if (yb >= TILES_HIGH) yb = TILES_HIGH - 1;
			// an inverted rectangle falls through both loops
			for (y = ya; y <= yb; y++)
				for (x = xa; x <= xb; x++)
					shadow_map[y * TILES_WIDE + x] = 1'b1;
			r.on_screen = 1'b1;
		end else begin
			for (int n = TILE_COUNT - 1; n >= 0; n--) begin
				if (shadow_map[n]) begin
					shadow_map[n] = 1'b0;
					r.found    = 1'b1;
					r.tile_row = TILE_ROW_W'(n / TILES_WIDE);
					r.tile_col = TILE_COL_W'(n % TILES_WIDE);
					break;
				end
			end
		end
		return r;
	endfunction

	// drives one word and returns at the edge where it is accepted
	task automatic send_word(input cmd_t c, input logic signed [COORD_W-1:0] lx, ty, rx, by);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c;
		s_axis_tdata  <= {by, rx, ty, lx};
		pending_results.push_back(predict_tile_result(c, lx, ty, rx, by));
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic send_take();
		send_word(CMD_TAKE, COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), COORD_W'($urandom));
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		tile_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result word, expected none, got %h",
					$time, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("on_screen", want.on_screen, m_axis_tdata[0]);
				check_field("found", want.found, m_axis_tdata[1]);
				check_field("tile_row", want.tile_row, m_axis_tdata[5:2]);
				check_field("tile_col", want.tile_col, m_axis_tdata[10:6]);
				check_field("padding", 0, m_axis_tdata[15:11]);
			end
		end
	end

	task automatic test_take_empty();
		send_take();
		send_take();
	endtask

	task automatic test_off_grid();
		send_word(CMD_MARK, 512, 0, 600, 10);
		send_word(CMD_MARK, 0, 256, 40, 300);
		send_word(CMD_MARK, -100, 0, -1, 10);
		send_word(CMD_MARK, 0, -100, 40, -1);
		send_word(CMD_MARK, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_word(CMD_MARK, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
	endtask

	task automatic test_corner_and_inverted();
		// last pixel of the grid, then a rectangle with left beyond right and one with top beyond bottom
		send_word(CMD_MARK, 511, 255, 511, 255);
		send_take();
		send_take();
		send_word(CMD_MARK, 200, 0, 100, 10);
		send_word(CMD_MARK, 0, 100, 10, 50);
		send_take();
	endtask

	task automatic test_partial_clip();
		send_word(CMD_MARK, -50, -50, 20, 20);
		send_take();
		send_take();
		send_word(CMD_MARK, 500, 240, 900, 700);
		send_take();
	endtask

	task automatic test_full_range();
		send_word(CMD_MARK, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_take();
		send_take();
	endtask

	task automatic test_random_traffic(input int items, input int send_pct, input int recv_pct);
		bit draining;
		int k, lx, ty, rx, by;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		draining = 1'b1;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(99) < 3)
				draining = !draining;
			if ($urandom_range(99) < (draining ? 85 : 30)) begin
				send_take();
			end else begin
				k = $urandom_range(99);
				if (k < 75) begin
					lx = int'($urandom_range(600)) - 40;
					ty = int'($urandom_range(330)) - 40;
					rx = lx + int'($urandom_range(24));
					by = ty + int'($urandom_range(24));
					if ($urandom_range(19) == 0) begin
						k  = lx;
						lx = rx + 16;
						rx = k;
					end
				end else if (k < 88) begin
					lx = int'($urandom_range(800)) - 200;
					ty = int'($urandom_range(500)) - 200;
					rx = lx + int'($urandom_range(600));
					by = ty + int'($urandom_range(300));
				end else begin
					lx = $urandom;
					ty = $urandom;
					rx = $urandom;
					by = $urandom;
				end
				send_word(CMD_MARK, lx[COORD_W-1:0], ty[COORD_W-1:0],
					rx[COORD_W-1:0], by[COORD_W-1:0]);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_take_empty();
		test_off_grid();
		test_corner_and_inverted();
		test_partial_clip();
		test_full_range();
		test_random_traffic(650, 7, 70);
		test_random_traffic(650, 70, 7);
		test_random_traffic(650, 0, 0);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TILES_HIGH + 8) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/dtt_pkg.sv
hw/rtl/dtt_decode.sv
hw/rtl/dtt_cell.sv
hw/rtl/dirty_tile_tracker_core.sv
dv/tb.sv
